// ===== rtl/core/fln_pkg.sv =====
// ----------------------------------------------------------------------------
// fln_pkg
// shared constants, codes and types of the fused layer norm / linear block
// ----------------------------------------------------------------------------
package fln_pkg;

  localparam int MAX_DIM     = 128;
  localparam int MAX_OUTPUTS = 64;
  localparam int DIM_W       = 7;   // element address
  localparam int OUT_W       = 6;   // output / cell number
  localparam int LEN_W       = 8;   // element count 0..MAX_DIM
  localparam int CNT_W       = 7;   // output count 0..MAX_OUTPUTS

  localparam int SUM_W   = 24;      // signed row sum
  localparam int MEAN_W  = 18;
  localparam int INV_W   = 33;      // inverse deviation, up to 2^32
  localparam int N_W     = 45;      // normalised element, kept wide
  localparam int ACC_W   = 70;      // cell accumulator
  localparam int DIV_N_W = 40;      // divider dividend / quotient
  localparam int DIV_D_W = 25;      // divider divisor
  localparam int VAR_W   = 34;      // variance plus epsilon
  localparam int RAD_W   = 50;      // root radicand
  localparam int ROOT_W  = 25;

  localparam logic [1:0] CMD_GAIN   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_BIAS   = 2'd2;
  localparam logic [1:0] CMD_DATA   = 2'd3;

  localparam logic [1:0] CFG_ROW_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_EPSILON      = 2'd2;
  localparam logic [1:0] CFG_BIAS_ENABLE  = 2'd3;

  typedef struct packed {
    logic                    v;
    logic [DIM_W-1:0]        d;
    logic signed [N_W-1:0]   n;
  } norm_beat_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               sat;
  } cell_res_t;

  typedef struct packed {
    logic               we;
    logic               is_bias;
    logic [DIM_W-1:0]   addr;
    logic [OUT_W-1:0]   sel;
    logic signed [15:0] data;
  } load_t;

  typedef struct packed {
    logic start;
    logic bias_en;
    logic capture;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/core/fln_if.sv =====
// ----------------------------------------------------------------------------
// fln_in_if / fln_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface fln_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [6:0]         elem_index;
  logic [5:0]         out_select;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;

  modport source (output valid, command, elem_index, out_select, value_a, value_b,
                  input ready);
  modport sink   (input valid, command, elem_index, out_select, value_a, value_b,
                  output ready);
endinterface

interface fln_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_index;
  logic signed [15:0] out_value;
  logic               is_last;
  logic               saturated;

  modport source (output valid, out_index, out_value, is_last, saturated,
                  input ready);
  modport sink   (input valid, out_index, out_value, is_last, saturated,
                  output ready);
endinterface

// ===== rtl/core/fln_div.sv =====
// ----------------------------------------------------------------------------
// fln_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fln_div import fln_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dvs;
  logic [5:0]         cnt;
  logic               busy;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem, quotient[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DIV_D_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_D_W-1:0];
      quotient <= {quotient[DIV_N_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/fln_sqrt.sv =====
// ----------------------------------------------------------------------------
// fln_sqrt
// integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module fln_sqrt import fln_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [4:0]       cnt;
  logic             busy;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = (REM_W+2)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/fln_cell.sv =====
// ----------------------------------------------------------------------------
// fln_cell
// one linear output: weight row, bias, accumulator, result slot
// ----------------------------------------------------------------------------
module fln_cell import fln_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [OUT_W-1:0] cell_id,
  input  cell_ctl_t        ctl,
  input  load_t            load,
  input  norm_beat_t       beat_in,
  output norm_beat_t       beat_out,
  input  cell_res_t        res_in,
  output cell_res_t        res_out
);

  logic signed [15:0]        wmem [MAX_DIM];
  logic signed [15:0]        w_q;
  logic signed [15:0]        bias;
  norm_beat_t                beat_a;
  logic signed [ACC_W-1:0]   acc;
  logic signed [N_W+15:0]    prod;
  logic signed [ACC_W-9:0]   r;
  logic                      hi;
  logic                      lo;
  cell_res_t                 res;

  always_ff @(posedge clk) begin
    if (load.we && !load.is_bias && load.sel == cell_id) begin
      wmem[load.addr] <= load.data;
    end
    w_q <= wmem[beat_in.d];
  end

  always_ff @(posedge clk) begin
    if (load.we && load.is_bias && load.sel == cell_id) begin
      bias <= load.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_a.v <= 1'b0;
    end else begin
      beat_a.v <= beat_in.v;
    end
    beat_a.d <= beat_in.d;
    beat_a.n <= beat_in.n;
  end

  assign prod = beat_a.n * w_q;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= ctl.bias_en ? (ACC_W'(bias) <<< 8) : '0;
    end else if (beat_a.v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign r  = (ACC_W-8)'(acc >>> 8);
  assign hi = !r[ACC_W-9] && (r[ACC_W-9:15] != '0);
  assign lo = r[ACC_W-9] && (r[ACC_W-9:15] != '1);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      res.sat   <= hi || lo;
      res.value <= hi ? 16'sh7fff : (lo ? 16'sh8000 : r[15:0]);
    end else if (ctl.shift) begin
      res <= res_in;
    end
  end

  assign beat_out = beat_a;
  assign res_out  = res;

endmodule

// ===== rtl/core/fused_layernorm_linear.sv =====
// ----------------------------------------------------------------------------
// fused_layernorm_linear
// layer normalisation of a Q8.8 row followed by a linear layer
// ----------------------------------------------------------------------------
// Load beats (gain/offset, weight, bias) and row data beats are taken one
// per cycle while the block is idle. The data beat that writes element dim-1
// (row_length clamped to 1..MAX_DIM) starts the row work, during which no
// input beat is taken: a sum pass over the row store, a divide for the mean,
// a variance pass, a divide, a square root, a divide for the inverse
// deviation (skipped when the root is zero), then a normalise pass that
// streams each normalised element into a chain of 64 cells, one per linear
// output. Every cell holds its weight row and bias, multiplies the passing
// element by its weight and hands the element to its neighbour in the next
// cycle. After a drain the results shift out of the chain, one beat per
// cycle while the sink is ready. Stores read before being written give
// undefined results.
// ----------------------------------------------------------------------------
module fused_layernorm_linear import fln_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  fln_in_if.sink     in_ch,
  fln_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_MDIV  = 4'd2;
  localparam logic [3:0] S_VAR   = 4'd3;
  localparam logic [3:0] S_VDIV  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_IDIV  = 4'd6;
  localparam logic [3:0] S_NORM  = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // configuration
  logic [LEN_W-1:0] row_length;
  logic [CNT_W-1:0] output_count;
  logic [15:0]      epsilon_q16;
  logic             bias_enable;
  logic [LEN_W-1:0] dim;
  logic [CNT_W-1:0] outs;

  // row, gain and offset stores
  logic signed [15:0] row_mem  [MAX_DIM];
  logic signed [15:0] gain_mem [MAX_DIM];
  logic signed [15:0] off_mem  [MAX_DIM];
  logic signed [15:0] row_q;
  logic signed [15:0] gain_q;
  logic signed [15:0] off_q;

  logic [3:0]         state;
  logic [LEN_W-1:0]   scan_cnt;
  logic               scan_go;
  logic               v1;
  logic [DIM_W-1:0]   d1;
  logic               accept;

  // statistics
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_neg;
  logic signed [MEAN_W-1:0] mean;
  logic [DIV_N_W-1:0]       sumsq;
  logic signed [MEAN_W-1:0] dv;
  logic signed [2*MEAN_W-1:0] sq;
  logic [INV_W-1:0]         inv;

  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;
  logic               sq_start;
  logic [RAD_W-1:0]   sq_rad;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic [VAR_W-1:0]   var_eps;

  // normalise pipeline
  logic                            v2;
  logic                            v3;
  logic [DIM_W-1:0]                d2;
  logic [DIM_W-1:0]                d3;
  logic signed [MEAN_W+INV_W:0]    p1;
  logic signed [MEAN_W+INV_W-16:0] t;
  logic signed [MEAN_W+INV_W:0]    p2;
  logic signed [15:0]              gain2;
  logic signed [15:0]              off2;
  logic signed [15:0]              off3;
  norm_beat_t                      beats [MAX_OUTPUTS+1];
  cell_res_t                       res   [MAX_OUTPUTS+1];

  // cell control and output
  logic             cell_start;
  logic             capture;
  logic [CNT_W-1:0] drain_cnt;
  logic [CNT_W-1:0] remain;
  logic [OUT_W-1:0] idx;
  logic             emit;
  cell_ctl_t        ctl;
  load_t            load;

  assign dim  = (row_length == '0) ? LEN_W'(1)
              : ((row_length > LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM) : row_length);
  assign outs = (output_count == '0) ? CNT_W'(1)
              : ((output_count > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS) : output_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= LEN_W'(MAX_DIM);
      output_count <= CNT_W'(MAX_OUTPUTS);
      epsilon_q16  <= 16'd1;
      bias_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH:   row_length   <= cfg_data[LEN_W-1:0];
        CFG_OUTPUT_COUNT: output_count <= cfg_data[CNT_W-1:0];
        CFG_EPSILON:      epsilon_q16  <= cfg_data;
        CFG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // stores: written by load and data beats, read by the row passes
  always_ff @(posedge clk) begin
    if (accept && in_ch.command == CMD_DATA) begin
      row_mem[in_ch.elem_index] <= in_ch.value_a;
    end
    if (accept && in_ch.command == CMD_GAIN) begin
      gain_mem[in_ch.elem_index] <= in_ch.value_a;
      off_mem[in_ch.elem_index]  <= in_ch.value_b;
    end
    row_q  <= row_mem[scan_cnt[DIM_W-1:0]];
    gain_q <= gain_mem[scan_cnt[DIM_W-1:0]];
    off_q  <= off_mem[scan_cnt[DIM_W-1:0]];
  end

  // weight and bias loads go to every cell, the addressed one keeps them
  assign load.we      = accept && (in_ch.command == CMD_WEIGHT || in_ch.command == CMD_BIAS);
  assign load.is_bias = (in_ch.command == CMD_BIAS);
  assign load.addr    = in_ch.elem_index;
  assign load.sel     = in_ch.out_select;
  assign load.data    = in_ch.value_a;

  assign scan_go = (state == S_SUM || state == S_VAR || state == S_NORM) && (scan_cnt < dim);

  assign dv      = MEAN_W'(row_q) - mean;
  assign sq      = dv * dv;
  assign sum_neg = sum[SUM_W-1];
  assign var_eps = VAR_W'(div_q) + VAR_W'(epsilon_q16);
  assign emit    = (state == S_OUT) && !capture && (remain != '0)
                && (!out_ch.valid || out_ch.ready);

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      v1         <= 1'b0;
      div_start  <= 1'b0;
      sq_start   <= 1'b0;
      cell_start <= 1'b0;
      capture    <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      div_start  <= 1'b0;
      sq_start   <= 1'b0;
      cell_start <= 1'b0;
      capture    <= 1'b0;
      v1         <= scan_go;
      if (scan_go) begin
        scan_cnt <= scan_cnt + LEN_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_ch.command == CMD_DATA
              && LEN_W'(in_ch.elem_index) == dim - LEN_W'(1)) begin
            state    <= S_SUM;
            scan_cnt <= '0;
          end
        end
        S_SUM: begin
          if (scan_cnt == dim && !v1) begin
            state     <= S_MDIV;
            div_start <= 1'b1;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            state    <= S_VAR;
            scan_cnt <= '0;
          end
        end
        S_VAR: begin
          if (scan_cnt == dim && !v1) begin
            state     <= S_VDIV;
            div_start <= 1'b1;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            state    <= S_SQRT;
            sq_start <= 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              state      <= S_NORM;
              scan_cnt   <= '0;
              cell_start <= 1'b1;
            end else begin
              state     <= S_IDIV;
              div_start <= 1'b1;
            end
          end
        end
        S_IDIV: begin
          if (div_done) begin
            state      <= S_NORM;
            scan_cnt   <= '0;
            cell_start <= 1'b1;
          end
        end
        S_NORM: begin
          if (scan_cnt == dim && !v1 && !v2 && !v3 && !beats[0].v) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == CNT_W'(MAX_OUTPUTS + 2)) begin
            state   <= S_OUT;
            capture <= 1'b1;
          end
        end
        S_OUT: begin
          if (!capture && remain == '0 && (!out_ch.valid || out_ch.ready)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // statistics datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sum   <= '0;
      sumsq <= '0;
    end
    if (state == S_SUM && v1) begin
      sum <= sum + SUM_W'(row_q);
    end
    if (state == S_VAR && v1) begin
      sumsq <= sumsq + DIV_N_W'($unsigned(sq));
    end
    if (state == S_SUM && scan_cnt == dim && !v1) begin
      // floor division of a negative sum through its magnitude
      div_n <= sum_neg ? DIV_N_W'(-sum) + DIV_N_W'(dim - LEN_W'(1)) : DIV_N_W'(sum);
      div_d <= DIV_D_W'(dim);
    end
    if (state == S_MDIV && div_done) begin
      mean <= sum_neg ? -MEAN_W'(div_q) : MEAN_W'(div_q);
    end
    if (state == S_VAR && scan_cnt == dim && !v1) begin
      div_n <= sumsq;
      div_d <= DIV_D_W'(dim);
    end
    if (state == S_VDIV && div_done) begin
      sq_rad <= {var_eps, 16'd0};
    end
    if (state == S_SQRT && sq_done) begin
      div_n <= DIV_N_W'(1) << 32;
      div_d <= sq_root;
      inv   <= {1'b0, 32'hffff_ffff};
    end
    if (state == S_IDIV && div_done) begin
      inv <= div_q[INV_W-1:0];
    end
  end

  fln_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  fln_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // normalise: centre and scale, then gain, then offset
  assign t = (MEAN_W+INV_W-15)'(p1 >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2         <= 1'b0;
      v3         <= 1'b0;
      beats[0].v <= 1'b0;
    end else begin
      v2         <= v1 && state == S_NORM;
      v3         <= v2;
      beats[0].v <= v3;
    end
    d1          <= scan_cnt[DIM_W-1:0];
    p1          <= dv * $signed({1'b0, inv});
    gain2       <= gain_q;
    off2        <= off_q;
    d2          <= d1;
    p2          <= (MEAN_W+INV_W+1)'(t * gain2);
    off3        <= off2;
    d3          <= d2;
    beats[0].n  <= N_W'(p2 >>> 8) + N_W'(off3);
    beats[0].d  <= d3;
  end

  // drain count until the last element has passed the final cell
  always_ff @(posedge clk) begin
    if (state == S_DRAIN) begin
      drain_cnt <= drain_cnt + CNT_W'(1);
    end else begin
      drain_cnt <= '0;
    end
  end

  assign ctl.start   = cell_start;
  assign ctl.bias_en = bias_enable;
  assign ctl.capture = capture;
  assign ctl.shift   = emit;

  assign res[MAX_OUTPUTS] = '0;

  for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_cell
    fln_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (OUT_W'(k)),
      .ctl      (ctl),
      .load     (load),
      .beat_in  (beats[k]),
      .beat_out (beats[k+1]),
      .res_in   (res[k+1]),
      .res_out  (res[k])
    );
  end

  // output register, fed from the head of the result chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      remain       <= '0;
      idx          <= '0;
    end else begin
      if (capture) begin
        remain <= outs;
        idx    <= '0;
      end else if (emit) begin
        remain <= remain - CNT_W'(1);
        idx    <= idx + OUT_W'(1);
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.out_index <= idx;
      out_ch.out_value <= res[0].value;
      out_ch.saturated <= res[0].sat;
      out_ch.is_last   <= (remain == CNT_W'(1));
    end
  end

endmodule
